FILE: hdl/rmst_pkg.sv
// shared constants and codes for the range minimum segment tree
package rmst_pkg;

  // field widths of one item
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned RANGE_W = 11;

  // tree geometry
  localparam int unsigned LEAVES = 1024;
  localparam int unsigned LEAF_W = $clog2(LEAVES);
  localparam int unsigned NODE_W = LEAF_W + 1;   // node address, 2*LEAVES nodes
  localparam int unsigned NODES  = 2 * LEAVES;
  localparam int unsigned PTR_W  = NODE_W + 1;   // walk pointer, holds 2*LEAVES

  localparam logic [VAL_W-1:0] EMPTY_NODE = '1;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

endpackage

FILE: hdl/range_min_segment_tree_core.sv
// range minimum segment tree: node memory, update walk and query walk
//
// channel   direction  handshake           ports
// --------  ---------  ------------------  ---------------------------------------------
// command   in         start && !busy      func_i position_i value_i range_start_i
//                                          range_end_i
// result    out        done_o, one cycle   min_value_o
//
// clear:  one node written per cycle (whole node memory, one write port)
// update: the leaf is written in the accepting cycle, then each ancestor in turn up to the root
// query:  a walk up the tree, one level at a time while the range is open, a step to fold the
//         last reads and one to register the result; done_o high in the cycle busy drops
// reset:  the block starts with the same clearing pass, busy held high
// the result cannot be stalled; a new item may be taken in the cycle done_o is high
module range_min_segment_tree_core
  import rmst_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [POS_W-1:0]     position_i,
  input  logic [VAL_W-1:0]     value_i,
  input  logic [RANGE_W-1:0]   range_start_i,
  input  logic [RANGE_W-1:0]   range_end_i,
  output logic                 done_o,
  output logic [VAL_W-1:0]     min_value_o
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_UPD    = 5'b00100,
    S_QWALK  = 5'b01000,
    S_QDRAIN = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // node memory, one write port and two registered read ports
  logic [VAL_W-1:0]  mem [NODES];
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic [NODE_W-1:0] rd_a_addr, rd_b_addr;
  logic [VAL_W-1:0]  rd_a_q, rd_b_q;

  // walk state
  logic [NODE_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [VAL_W-1:0]  cur_q, cur_d;
  logic [PTR_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic              pend_a_q, pend_a_d, pend_b_q, pend_b_d;
  logic              seen_q, seen_d;
  logic [VAL_W-1:0]  best_q, best_d;
  logic              done_q, done_d;
  logic [VAL_W-1:0]  min_value_q, min_value_d;

  logic              accept;
  logic [NODE_W-1:0] leaf_node;
  logic [NODE_W-1:0] parent;
  logic [VAL_W-1:0]  upd_min;
  logic [PTR_W-1:0]  rs_ext, re_ext, rs_sat, re_sat;
  logic [PTR_W-1:0]  lo_step, hi_step, hi_last;
  logic [VAL_W-1:0]  cand_a, cand_b, fold_ab, fold_all;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign leaf_node = NODE_W'(LEAVES) + NODE_W'(position_i);
  assign parent    = node_q >> 1;
  assign upd_min   = (rd_a_q < cur_q) ? rd_a_q : cur_q;

  // query bounds saturate to the leaf count
  assign rs_ext = PTR_W'(range_start_i);
  assign re_ext = PTR_W'(range_end_i);
  assign rs_sat = (rs_ext > PTR_W'(LEAVES)) ? PTR_W'(LEAVES) : rs_ext;
  assign re_sat = (re_ext > PTR_W'(LEAVES)) ? PTR_W'(LEAVES) : re_ext;

  assign lo_step = lo_q + PTR_W'(lo_q[0]);
  assign hi_step = hi_q - PTR_W'(hi_q[0]);
  assign hi_last = hi_q - PTR_W'(1);

  // fold the nodes read in the previous cycle into the running minimum
  assign cand_a   = pend_a_q ? rd_a_q : EMPTY_NODE;
  assign cand_b   = pend_b_q ? rd_b_q : EMPTY_NODE;
  assign fold_ab  = (cand_a < best_q) ? cand_a : best_q;
  assign fold_all = (cand_b < fold_ab) ? cand_b : fold_ab;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    node_d      = node_q;
    cur_d       = cur_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pend_a_d    = 1'b0;
    pend_b_d    = 1'b0;
    seen_d      = seen_q;
    best_d      = best_q;
    done_d      = 1'b0;
    min_value_d = min_value_q;
    wr_en       = 1'b0;
    wr_addr     = clr_cnt_q;
    wr_data     = EMPTY_NODE;
    rd_a_addr   = lo_q[NODE_W-1:0];
    rd_b_addr   = hi_last[NODE_W-1:0];

    case (state_q)
      S_CLEAR: begin
        // sweep every node back to the empty value
        wr_en     = 1'b1;
        clr_cnt_d = clr_cnt_q + NODE_W'(1);
        if (clr_cnt_q == NODE_W'(NODES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_CLEAR: begin
              clr_cnt_d = '0;
              state_d   = S_CLEAR;
            end
            FUNC_UPDATE: begin
              if (PTR_W'(position_i) < PTR_W'(LEAVES)) begin
                // write the leaf and fetch its sibling in the same cycle
                wr_en     = 1'b1;
                wr_addr   = leaf_node;
                wr_data   = value_i;
                rd_a_addr = leaf_node ^ NODE_W'(1);
                node_d    = leaf_node;
                cur_d     = value_i;
                state_d   = S_UPD;
              end
            end
            FUNC_QUERY: begin
              lo_d    = rs_sat + PTR_W'(LEAVES);
              hi_d    = re_sat + PTR_W'(LEAVES);
              best_d  = EMPTY_NODE;
              seen_d  = 1'b0;
              state_d = S_QWALK;
            end
            default: begin
              // unused code, dropped
            end
          endcase
        end
      end
      S_UPD: begin
        // parent gets min of the path value and the sibling just read
        wr_en     = 1'b1;
        wr_addr   = parent;
        wr_data   = upd_min;
        cur_d     = upd_min;
        node_d    = parent;
        rd_a_addr = parent ^ NODE_W'(1);
        if (parent == NODE_W'(1)) begin
          state_d = S_IDLE;
        end
      end
      S_QWALK: begin
        best_d = fold_all;
        seen_d = seen_q || pend_a_q || pend_b_q;
        if (lo_q < hi_q) begin
          // odd left bound and odd right bound each pick one node
          pend_a_d = lo_q[0];
          pend_b_d = hi_q[0];
          lo_d     = lo_step >> 1;
          hi_d     = hi_step >> 1;
        end else begin
          state_d = S_QDRAIN;
        end
      end
      S_QDRAIN: begin
        done_d      = 1'b1;
        min_value_d = (seen_q || pend_a_q || pend_b_q) ? fold_all : '0;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      pend_a_q  <= 1'b0;
      pend_b_q  <= 1'b0;
      seen_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      pend_a_q  <= pend_a_d;
      pend_b_q  <= pend_b_d;
      seen_q    <= seen_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q      <= node_d;
    cur_q       <= cur_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    best_q      <= best_d;
    min_value_q <= min_value_d;
  end

  assign done_o      = done_q;
  assign min_value_o = min_value_q;

  // a result only ever follows the fold at the end of a query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_QDRAIN))
    else $error("result strobe without a finished query");

  // no node read may be left unfolded once the block is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!pend_a_q && !pend_b_q))
    else $error("pending node read while idle");

  // the update walk never goes past the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (node_q >= NODE_W'(2)))
    else $error("update walk at or above the root");

  // an accepted query enters the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FUNC_QUERY) |=> (state_q == S_QWALK))
    else $error("query not started");

endmodule

FILE: dv/range_min_segment_tree_core_tb.sv
// testbench for the range minimum segment tree core, random items checked against a tree model
module range_min_segment_tree_core_tb;
  import rmst_pkg::*;

  // func code 3 has no meaning, the block must swallow it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 2000;
  // no acceptance and no result for this long means the block is stuck
  localparam int unsigned STALL_LIMIT  = 20000;
  // settle time after the last result
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned IDLE_PCT     = 27;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [POS_W-1:0]   position;
    logic [VAL_W-1:0]   value;
    logic [RANGE_W-1:0] range_start;
    logic [RANGE_W-1:0] range_end;
  } tree_cmd_t;

  // expected minimum plus the range it came from, for the mismatch report
  typedef struct {
    logic [VAL_W-1:0]   min_value;
    logic [RANGE_W-1:0] range_start;
    logic [RANGE_W-1:0] range_end;
  } open_query_t;

  // shadow copy of the node memory and the queries still waiting for a result
  class min_tree_scoreboard;
    logic [VAL_W-1:0] node_min [NODES];
    open_query_t      open_queries [$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
      empty_tree();
    endfunction

    function void empty_tree();
      foreach (node_min[n]) node_min[n] = EMPTY_NODE;
    endfunction

    function int unsigned pending();
      return open_queries.size();
    endfunction

    // apply one accepted item to the shadow tree, queue a minimum for a query
    function void note_item(tree_cmd_t cmd);
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      node;
      logic [VAL_W-1:0] best;
      bit               seen;
      open_query_t      q;
      case (cmd.func)
        FUNC_CLEAR: empty_tree();
        FUNC_UPDATE: begin
          if (cmd.position < LEAVES) begin
            node = LEAVES + cmd.position;
            node_min[node] = cmd.value;
            node = node >> 1;
            // refresh every ancestor up to the root
            while (node > 0) begin
              node_min[node] = (node_min[2*node] < node_min[2*node+1]) ?
                               node_min[2*node] : node_min[2*node+1];
              node = node >> 1;
            end
          end
        end
        FUNC_QUERY: begin
          // bounds past the last leaf are clipped to LEAVES
          lo = (cmd.range_start > LEAVES) ? LEAVES : cmd.range_start;
          hi = (cmd.range_end > LEAVES) ? LEAVES : cmd.range_end;
          lo += LEAVES;
          hi += LEAVES;
          best = EMPTY_NODE;
          seen = 1'b0;
          // bottom-up walk: odd left edge and odd right edge stick out of their parents
          while (lo < hi) begin
            if (lo[0]) begin
              if (node_min[lo] < best) best = node_min[lo];
              lo++;
              seen = 1'b1;
            end
            if (hi[0]) begin
              hi--;
              if (node_min[hi] < best) best = node_min[hi];
              seen = 1'b1;
            end
            lo = lo >> 1;
            hi = hi >> 1;
          end
          // an empty range reads as zero, not as the empty marker
          q.min_value   = seen ? best : '0;
          q.range_start = cmd.range_start;
          q.range_end   = cmd.range_end;
          open_queries.push_back(q);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [VAL_W-1:0] got);
      open_query_t q;
      if (open_queries.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: min_value %h with no query outstanding", got);
        return;
      end
      q = open_queries.pop_front();
      if (got !== q.min_value) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("min_value mismatch for range [%0d,%0d): expected %h, got %h",
                   q.range_start, q.range_end, q.min_value, got);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [FUNC_W-1:0]  func_i;
  logic [POS_W-1:0]   position_i;
  logic [VAL_W-1:0]   value_i;
  logic [RANGE_W-1:0] range_start_i;
  logic [RANGE_W-1:0] range_end_i;
  logic               done_o;
  logic [VAL_W-1:0]   min_value_o;

  min_tree_scoreboard sb = new();
  bit                 no_idle;
  int unsigned        stall_cycles;

  range_min_segment_tree_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .done_o        (done_o),
    .min_value_o   (min_value_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // results cannot be held off, so every strobe is checked at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_result(min_value_o);
  end

  // watchdog on progress: any accepted item or result restarts the count
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic tree_cmd_t cmd_of(logic [FUNC_W-1:0] func, int unsigned position,
                                       int unsigned value,
                                       int unsigned range_start,
                                       int unsigned range_end);
    tree_cmd_t cmd;
    cmd.func        = func;
    cmd.position    = POS_W'(position);
    cmd.value       = VAL_W'(value);
    cmd.range_start = RANGE_W'(range_start);
    cmd.range_end   = RANGE_W'(range_end);
    return cmd;
  endfunction

  // called just after a rising edge; returns at the edge that took the item
  // start only drops during an idle cycle, so it never gets two updates in one step
  task automatic send_cmd(input tree_cmd_t cmd);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    func_i        <= cmd.func;
    position_i    <= cmd.position;
    value_i       <= cmd.value;
    range_start_i <= cmd.range_start;
    range_end_i   <= cmd.range_end;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_item(cmd);
  endtask

  // sender holds off until every outstanding query has answered
  task automatic drain_results();
    while (sb.pending() != 0) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  initial begin
    tree_cmd_t   cmd;
    tree_cmd_t   directed [$];
    int unsigned issued;
    int unsigned pick;
    int unsigned focus;
    int unsigned lo;

    rst_ni        = 1'b0;
    start         = 1'b0;
    func_i        = FUNC_CLEAR;
    position_i    = '0;
    value_i       = '0;
    range_start_i = '0;
    range_end_i   = '0;
    no_idle       = 1'b0;
    stall_cycles  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: fresh tree, empty ranges, edge leaves, saturation, stored all ones,
    // ignored code, clear
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 0, LEAVES));       // never written
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 5, 5));            // empty range
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 10, 3));           // reversed range
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 2047, 2047));      // both clipped
    directed.push_back(cmd_of(FUNC_UPDATE, 0, 32'h0, 0, 0));
    directed.push_back(cmd_of(FUNC_UPDATE, 1023, 32'hFFFF_FFFE, 0, 0));
    directed.push_back(cmd_of(FUNC_UPDATE, 512, 32'h8000_0000, 0, 0));
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 0, 1));
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 1023, 1024));
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 1, 1023));
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 1, 2047));         // end clipped
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 1024, 2047));      // start at the top
    directed.push_back(cmd_of(FUNC_UNUSED, 1023, 32'h0, 0, LEAVES));
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 0, LEAVES));
    directed.push_back(cmd_of(FUNC_UPDATE, 0, EMPTY_NODE, 0, 0));  // all ones looks empty
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 0, 1));
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 0, LEAVES));
    directed.push_back(cmd_of(FUNC_CLEAR, 0, 0, 0, 0));
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 0, LEAVES));
    directed.push_back(cmd_of(FUNC_UPDATE, 700, 32'd123, 0, 0));
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 0, 2047));
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 700, 701));
    directed.push_back(cmd_of(FUNC_QUERY, 0, 0, 701, 1024));
    foreach (directed[i]) send_cmd(directed[i]);
    drain_results();

    // random: updates clustered around a moving window so narrow queries see real data,
    // wide and clipped ranges, empty ranges, rare clears and a little noise
    focus  = $urandom_range(LEAVES - 1);
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      no_idle = (issued >= 1200 && issued < 1500);
      if (issued == 1000) drain_results();
      if ($urandom_range(15) == 0) focus = $urandom_range(LEAVES - 1);
      pick             = $urandom_range(99);
      cmd.position     = POS_W'($urandom);
      cmd.value        = $urandom;
      cmd.range_start  = RANGE_W'($urandom);
      cmd.range_end    = RANGE_W'($urandom);
      if (pick < 1) begin
        cmd.func = FUNC_CLEAR;
      end else if (pick < 4) begin
        cmd.func = FUNC_UNUSED;
      end else if (pick < 50) begin
        cmd.func = FUNC_UPDATE;
        if ($urandom_range(1)) cmd.position = POS_W'(focus + $urandom_range(31));
        case ($urandom_range(3))
          0: cmd.value = $urandom_range(255);
          1: cmd.value = EMPTY_NODE;
          default: ;
        endcase
      end else begin
        cmd.func = FUNC_QUERY;
        case ($urandom_range(4))
          0: ;  // raw 11-bit bounds, mostly clipped
          1: begin
            lo = $urandom_range(LEAVES);
            cmd.range_start = RANGE_W'(lo);
            cmd.range_end   = RANGE_W'($urandom_range(LEAVES, lo));
          end
          2: begin
            cmd.range_start = RANGE_W'(focus);
            cmd.range_end   = RANGE_W'(focus + 1 + $urandom_range(40));
          end
          3: begin
            lo = $urandom_range(LEAVES);
            cmd.range_start = RANGE_W'(lo);
            cmd.range_end   = RANGE_W'($urandom_range(lo));
          end
          default: begin
            cmd.range_start = RANGE_W'($urandom_range(3));
            cmd.range_end   = RANGE_W'(LEAVES - $urandom_range(3));
          end
        endcase
      end
      send_cmd(cmd);
      if (cmd.func != FUNC_UNUSED) issued++;
    end

    drain_results();
    start <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: range_min_segment_tree_core.f
hdl/rmst_pkg.sv
hdl/range_min_segment_tree_core.sv
dv/range_min_segment_tree_core_tb.sv
